FILE: src/msie_pkg.sv
// ----------------------------------------------------------------------------
// msie_pkg
// shared types, opcodes and constants for the mips subset executor
// ----------------------------------------------------------------------------
package msie_pkg;

    localparam int          DMEM_WORDS_DEF = 1024;
    localparam int          REG_COUNT      = 32;
    localparam logic [31:0] START_PC_RESET = 32'h0040_0000;
    localparam logic [31:0] GP_INIT        = 32'h1000_8000;
    localparam logic [31:0] DMEM_BASE      = 32'h1000_0000;
    localparam logic [31:0] PC_HI_MASK     = 32'hf000_0000;
    localparam logic [4:0]  REG_GP         = 5'd28;
    localparam logic [4:0]  REG_SP         = 5'd29;
    localparam logic [4:0]  REG_RA         = 5'd31;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_TRAP    = 6'h1a;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT  = 6'h2a;

    localparam logic [3:0] TR_NEWLINE = 4'h0;
    localparam logic [3:0] TR_PRINT   = 4'h1;
    localparam logic [3:0] TR_READ    = 4'h5;
    localparam logic [3:0] TR_HALT    = 4'ha;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_NEWLINE  = 3'd1;
    localparam logic [2:0] EV_PRINT    = 3'd2;
    localparam logic [2:0] EV_HALT     = 3'd3;
    localparam logic [2:0] EV_BADINSTR = 3'd4;
    localparam logic [2:0] EV_BADTRAP  = 3'd5;

    typedef struct packed {
        logic [31:0]        instruction;
        logic signed [31:0] console_value;
    } t_in;

    typedef struct packed {
        logic [31:0]        next_pc;
        logic [2:0]         event_res;
        logic signed [31:0] print_value;
    } t_out;

    typedef struct packed {
        logic ld_in;
        logic sel_rt;
        logic ld_a;
        logic exe;
        logic mem_wb;
        logic div_wb;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic need_mem;
        logic need_div;
        logic div_done;
        logic out_busy;
    } t_sts;

    function automatic logic [31:0] reg_init(input logic [4:0] idx, input logic [31:0] sp);
        logic [31:0] v;
        v = 32'd0;
        if (idx == REG_GP) begin
            v = GP_INIT;
        end else if (idx == REG_SP) begin
            v = sp;
        end
        return v;
    endfunction

endpackage

FILE: src/mips_subset_instruction_executor.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor
// executes one mips32 subset instruction word per request
// ----------------------------------------------------------------------------
// Each request carries one instruction word fetched at the last reported pc
// and yields one result with the next fetch pc and an event code. An
// instruction passes through register file read states for rs and then rt
// (its single read port), an execute state and a wait state before the
// output register; lw adds a registered data memory read and div with a
// non-zero divisor adds 32 radix-2 divider steps. A new request is taken
// once the previous result is in the output register, so results may
// wait while the next instruction runs. Writing the configuration register
// sets the start pc and reloads the program counter.
module mips_subset_instruction_executor #(
    parameter int DMEM_WORDS = msie_pkg::DMEM_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  msie_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output msie_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata
);
    msie_pkg::t_cmd cmd;
    msie_pkg::t_sts sts;

    msie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    msie_dp #(
        .DMEM_WORDS (DMEM_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule

FILE: src/msie_ram.sv
// ----------------------------------------------------------------------------
// msie_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module msie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/msie_div.sv
// ----------------------------------------------------------------------------
// msie_div
// signed 32-bit divider, one restoring step per cycle
// ----------------------------------------------------------------------------
module msie_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic        r_nq;
    logic        r_nr;
    logic [32:0] sh;
    logic [32:0] diff;

    assign sh   = {r_rem, r_quo[31]};
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= i_num[31] ? (32'd0 - i_num) : i_num;
            r_den <= i_den[31] ? (32'd0 - i_den) : i_den;
            r_nq  <= i_num[31] ^ i_den[31];
            r_nr  <= i_num[31];
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_nq ? (32'd0 - r_quo) : r_quo;
    assign o_rem  = r_nr ? (32'd0 - r_rem) : r_rem;
endmodule

FILE: src/msie_dp.sv
// ----------------------------------------------------------------------------
// msie_dp
// datapath: pc, register file, hi/lo, data memory, divider, result register
// ----------------------------------------------------------------------------
module msie_dp #(
    parameter int DMEM_WORDS = msie_pkg::DMEM_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  msie_pkg::t_in  i_in,
    input  msie_pkg::t_cmd i_cmd,
    output msie_pkg::t_sts o_sts,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output msie_pkg::t_out o_out
);
    localparam int          AW      = $clog2(DMEM_WORDS);
    localparam logic [31:0] SP_INIT = 32'(64'(msie_pkg::DMEM_BASE) + 64'(DMEM_WORDS) * 64'd4);

    logic [31:0]    r_ins;
    logic [31:0]    r_con;
    logic [31:0]    r_a;
    logic [31:0]    r_pc;
    logic [31:0]    r_hi;
    logic [31:0]    r_lo;
    logic           r_halted;
    logic [31:0]    r_rf_vld;
    logic [4:0]     r_lw_rt;
    logic           r_lw_ok;
    msie_pkg::t_out r_res;
    msie_pkg::t_out r_out;
    logic           r_out_vld;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [15:0] uimm;
    logic [31:0] simm, pc4, target;
    logic [31:0] rf_rdata, a_now, b;
    logic [4:0]  rf_raddr;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [31:0] ea, off;
    logic [29:0] widx;
    logic        in_rng;
    logic [31:0] dm_rdata;
    logic signed [63:0] prod;

    logic        wr_en, mult_we, halt_set, st_en, is_lw, is_div;
    logic [4:0]  wr_idx;
    logic [31:0] wr_data, npc, pv;
    logic [2:0]  ev;
    logic        div_done;
    logic [31:0] div_quo, div_rem;

    assign op     = r_ins[31:26];
    assign rs     = r_ins[25:21];
    assign rt     = r_ins[20:16];
    assign rd     = r_ins[15:11];
    assign sh     = r_ins[10:6];
    assign fn     = r_ins[5:0];
    assign uimm   = r_ins[15:0];
    assign simm   = {{16{uimm[15]}}, uimm};
    assign target = {6'd0, r_ins[25:0]};
    assign pc4    = r_pc + 32'd4;

    assign rf_raddr = i_cmd.sel_rt ? rt : rs;
    assign a_now    = r_rf_vld[rs] ? rf_rdata : msie_pkg::reg_init(rs, SP_INIT);
    assign b        = r_rf_vld[rt] ? rf_rdata : msie_pkg::reg_init(rt, SP_INIT);

    assign ea     = r_a + simm;
    assign off    = ea - msie_pkg::DMEM_BASE;
    assign widx   = off[31:2];
    assign in_rng = widx < 30'(DMEM_WORDS);
    assign prod   = $signed(r_a) * $signed(b);

    always_comb begin
        wr_en    = 1'b0;
        wr_idx   = rd;
        wr_data  = 32'd0;
        npc      = pc4;
        ev       = msie_pkg::EV_NONE;
        pv       = 32'd0;
        mult_we  = 1'b0;
        halt_set = 1'b0;
        st_en    = 1'b0;
        is_lw    = 1'b0;
        is_div   = 1'b0;
        if (r_halted) begin
            npc = r_pc;
            ev  = msie_pkg::EV_HALT;
        end else begin
            unique case (op)
                msie_pkg::OP_SPECIAL: begin
                    unique case (fn)
                        msie_pkg::FN_SLL: begin
                            wr_en = 1'b1; wr_data = b << sh;
                        end
                        msie_pkg::FN_SRA: begin
                            wr_en = 1'b1; wr_data = $signed(b) >>> sh;
                        end
                        msie_pkg::FN_JR:   npc = r_a;
                        msie_pkg::FN_MFHI: begin
                            wr_en = 1'b1; wr_data = r_hi;
                        end
                        msie_pkg::FN_MFLO: begin
                            wr_en = 1'b1; wr_data = r_lo;
                        end
                        msie_pkg::FN_MULT: mult_we = 1'b1;
                        msie_pkg::FN_DIV:  is_div = (b != 32'd0);
                        msie_pkg::FN_ADDU: begin
                            wr_en = 1'b1; wr_data = r_a + b;
                        end
                        msie_pkg::FN_SUBU: begin
                            wr_en = 1'b1; wr_data = r_a - b;
                        end
                        msie_pkg::FN_SLT: begin
                            wr_en = 1'b1; wr_data = {31'd0, $signed(r_a) < $signed(b)};
                        end
                        default: ev = msie_pkg::EV_BADINSTR;
                    endcase
                end
                msie_pkg::OP_J: npc = (pc4 & msie_pkg::PC_HI_MASK) | (target << 2);
                msie_pkg::OP_JAL: begin
                    wr_en   = 1'b1;
                    wr_idx  = msie_pkg::REG_RA;
                    wr_data = pc4;
                    npc     = (pc4 & msie_pkg::PC_HI_MASK) | (target << 2);
                end
                msie_pkg::OP_BEQ: if (r_a == b) npc = pc4 + (simm << 2);
                msie_pkg::OP_BNE: if (r_a != b) npc = pc4 + (simm << 2);
                msie_pkg::OP_ADDIU: begin
                    wr_en = 1'b1; wr_idx = rt; wr_data = r_a + simm;
                end
                msie_pkg::OP_ANDI: begin
                    wr_en = 1'b1; wr_idx = rt; wr_data = r_a & {16'd0, uimm};
                end
                msie_pkg::OP_LUI: begin
                    wr_en = 1'b1; wr_idx = rt; wr_data = {uimm, 16'd0};
                end
                msie_pkg::OP_TRAP: begin
                    unique case (r_ins[3:0])
                        msie_pkg::TR_NEWLINE: ev = msie_pkg::EV_NEWLINE;
                        msie_pkg::TR_PRINT: begin
                            ev = msie_pkg::EV_PRINT; pv = r_a;
                        end
                        msie_pkg::TR_READ: begin
                            wr_en = 1'b1; wr_idx = rt; wr_data = r_con;
                        end
                        msie_pkg::TR_HALT: begin
                            ev = msie_pkg::EV_HALT; halt_set = 1'b1;
                        end
                        default: begin
                            ev = msie_pkg::EV_BADTRAP; halt_set = 1'b1;
                        end
                    endcase
                end
                msie_pkg::OP_LW: is_lw = 1'b1;
                msie_pkg::OP_SW: st_en = in_rng;
                default: ev = msie_pkg::EV_BADINSTR;
            endcase
        end
    end

    always_comb begin
        if (i_cmd.mem_wb) begin
            rf_we    = (r_lw_rt != 5'd0);
            rf_waddr = r_lw_rt;
            rf_wdata = r_lw_ok ? dm_rdata : 32'd0;
        end else begin
            rf_we    = i_cmd.exe && wr_en && (wr_idx != 5'd0);
            rf_waddr = wr_idx;
            rf_wdata = wr_data;
        end
    end

    msie_ram #(
        .WIDTH (32),
        .DEPTH (msie_pkg::REG_COUNT)
    ) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    msie_ram #(
        .WIDTH (32),
        .DEPTH (DMEM_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exe && st_en),
        .i_waddr (widx[AW-1:0]),
        .i_wdata (b),
        .i_raddr (widx[AW-1:0]),
        .o_rdata (dm_rdata)
    );

    msie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.exe && is_div),
        .i_num   (r_a),
        .i_den   (b),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= msie_pkg::START_PC_RESET;
            r_hi      <= 32'd0;
            r_lo      <= 32'd0;
            r_halted  <= 1'b0;
            r_rf_vld  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end else if (i_cmd.exe) begin
                r_pc <= npc;
            end
            if (rf_we) begin
                r_rf_vld[rf_waddr] <= 1'b1;
            end
            if (i_cmd.exe && mult_we) begin
                r_hi <= prod[63:32];
                r_lo <= prod[31:0];
            end else if (i_cmd.div_wb) begin
                r_hi <= div_rem;
                r_lo <= div_quo;
            end
            if (i_cmd.exe && halt_set) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.out_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_ins <= i_in.instruction;
            r_con <= i_in.console_value;
        end
        if (i_cmd.ld_a) begin
            r_a <= a_now;
        end
        if (i_cmd.exe) begin
            r_lw_rt           <= rt;
            r_lw_ok           <= in_rng;
            r_res.next_pc     <= npc;
            r_res.event_res   <= ev;
            r_res.print_value <= pv;
        end
        if (i_cmd.out_ld) begin
            r_out <= r_res;
        end
    end

    assign o_sts.need_mem = is_lw;
    assign o_sts.need_div = is_div;
    assign o_sts.div_done = div_done;
    assign o_sts.out_busy = r_out_vld && !i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out          = r_out;
endmodule

FILE: src/msie_ctrl.sv
// ----------------------------------------------------------------------------
// msie_ctrl
// instruction sequencer: operand reads, execute, load, divide, result
// ----------------------------------------------------------------------------
module msie_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  msie_pkg::t_sts i_sts,
    output msie_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RS   = 3'd1;
    localparam logic [2:0] S_RT   = 3'd2;
    localparam logic [2:0] S_EXE  = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.ld_in = i_in_valid;
                if (i_in_valid) n_state = S_RS;
            end
            S_RS: n_state = S_RT;
            S_RT: begin
                o_cmd.sel_rt = 1'b1;
                o_cmd.ld_a   = 1'b1;
                n_state      = S_EXE;
            end
            S_EXE: begin
                o_cmd.exe = 1'b1;
                if (i_sts.need_mem) begin
                    n_state = S_MEM;
                end else if (i_sts.need_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MEM: begin
                o_cmd.mem_wb = 1'b1;
                n_state      = S_DONE;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wb = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

FILE: src/msie_chk.sv
// ----------------------------------------------------------------------------
// msie_chk
// port checks for the mips subset executor
// ----------------------------------------------------------------------------
module msie_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input msie_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input msie_pkg::t_out o_out,
    input logic           i_cfg_we,
    input logic [31:0]    i_cfg_wdata
);
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.event_res <= msie_pkg::EV_BADTRAP)
        else $error("event code out of range");

    a_pv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.event_res != msie_pkg::EV_PRINT |-> o_out.print_value == 32'sd0)
        else $error("print value set without print event");

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");
endmodule

bind mips_subset_instruction_executor msie_chk u_msie_chk (.*);
